// File: rtl/waveform_unpack_peak_sum_assert.svh
// ----------------------------------------------------------------------------
// Waveform unpack peak sum assertion macros
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_UNPACK_PEAK_SUM_ASSERT_SVH
`define WAVEFORM_UNPACK_PEAK_SUM_ASSERT_SVH

`ifndef SYNTHESIS
`define WUPS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define WUPS_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define WUPS_ASSERT(label, clk, rst, prop)
`define WUPS_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

// File: rtl/wups_pkg.sv
// ----------------------------------------------------------------------------
// Waveform unpack peak sum package
// Shared widths, codes and structures of the waveform statistics block.
// ----------------------------------------------------------------------------
package wups_pkg;

   localparam int MAX_WORDS_DEFAULT = 1024;

   localparam int WORD_W   = 32;
   localparam int LEFT_W   = 16;
   localparam int COUNT_W  = 11;
   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 43;
   localparam int OSUM_W   = 42;
   localparam int HALF_W   = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 184;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPW        = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DATA_WORDS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIN_START  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WIN_STOP   = 2'd3;

   localparam logic [1:0] SPW_ONE = 2'd1;
   localparam logic [1:0] SPW_TWO = 2'd2;

   localparam logic [1:0] SPW_RESET        = SPW_TWO;
   localparam logic [COUNT_W-1:0] DW_RESET = 11'd1024;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SHORT   = 2'd1,
      STATUS_BAD_SPW = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         spw;
      logic [COUNT_W-1:0] data_words;
      logic [COUNT_W-1:0] win_start;
      logic [COUNT_W-1:0] win_stop;
   } cfg_type;

   typedef struct packed {
      logic [OSUM_W-1:0]  window_sum;
      logic [OSUM_W-1:0]  total_sum;
      logic [COUNT_W-1:0] min_index;
      logic [WORD_W-1:0]  min_value;
      logic [COUNT_W-1:0] max_index;
      logic [WORD_W-1:0]  max_value;
      logic [COUNT_W-1:0] used_words;
      status_type         status;
   } rsp_type;

endpackage

// File: rtl/wups_core.sv
// ----------------------------------------------------------------------------
// Waveform unpack peak sum core
// Per-event running state and the update of peak, trough and
// sums for one raw word, with the event-start checks.
// ----------------------------------------------------------------------------
module wups_core
   import wups_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [WORD_W-1:0] data_word,
   input  logic [LEFT_W-1:0] words_left,
   input  cfg_type           cfg,
   output logic              emit,
   output rsp_type           rsp
);

   localparam int MaxLen = (MAX_WORDS > 2047) ? 2047 : MAX_WORDS;

   logic [COUNT_W-1:0]  word_count_ff, word_count_in;
   logic [SAMPLE_W-1:0] sample_count_ff, sample_count_in;
   logic [WORD_W-1:0]   max_ff, max_in, min_ff, min_in;
   logic [COUNT_W-1:0]  max_idx_ff, max_idx_in, min_idx_ff, min_idx_in;
   logic [SUM_W-1:0]    sum_ff, sum_in, wsum_ff, wsum_in;
   logic                ev_two_ff, ev_two_in;
   logic [COUNT_W-1:0]  ev_len_ff, ev_len_in, ev_start_ff, ev_start_in;
   logic [COUNT_W-1:0]  ev_stop_ff, ev_stop_in;

   logic [COUNT_W-1:0]  len;
   logic                first, short_buf, bad_spw, err, done, win_ok;
   logic [WORD_W-1:0]   lo, hi, pmax, pmin;
   logic [SAMPLE_W-1:0] idx_lo, idx_hi, pmax_idx, pmin_idx, base_sc;
   logic                in_lo, in_hi;
   logic [WORD_W-1:0]   base_max, base_min;
   logic [COUNT_W-1:0]  base_max_idx, base_min_idx;
   logic [SUM_W-1:0]    base_sum, base_wsum, add_hi, wadd_lo, wadd_hi;

   always_comb begin
      if (cfg.data_words == '0) begin
         len = COUNT_W'(1);
      end else if (cfg.data_words > COUNT_W'(MaxLen)) begin
         len = COUNT_W'(MaxLen);
      end else begin
         len = cfg.data_words;
      end
   end

   assign first     = (word_count_ff == '0);
   assign short_buf = words_left < LEFT_W'(len);
   assign bad_spw   = (cfg.spw != SPW_ONE) && (cfg.spw != SPW_TWO);
   assign err       = first && (short_buf || bad_spw);

   assign ev_two_in   = first ? (cfg.spw == SPW_TWO) : ev_two_ff;
   assign ev_len_in   = first ? len           : ev_len_ff;
   assign ev_start_in = first ? cfg.win_start : ev_start_ff;
   assign ev_stop_in  = first ? cfg.win_stop  : ev_stop_ff;

   assign base_sc      = first ? '0 : sample_count_ff;
   assign base_max     = first ? '0 : max_ff;
   assign base_max_idx = first ? '0 : max_idx_ff;
   assign base_min     = first ? '1 : min_ff;
   assign base_min_idx = first ? '0 : min_idx_ff;
   assign base_sum     = first ? '0 : sum_ff;
   assign base_wsum    = first ? '0 : wsum_ff;

   assign lo     = ev_two_in ? {{(WORD_W-HALF_W){1'b0}}, data_word[HALF_W-1:0]} : data_word;
   assign hi     = {{(WORD_W-HALF_W){1'b0}}, data_word[WORD_W-1:HALF_W]};
   assign idx_lo = base_sc;
   assign idx_hi = base_sc + SAMPLE_W'(1);

   always_comb begin
      pmax     = lo;
      pmax_idx = idx_lo;
      pmin     = lo;
      pmin_idx = idx_lo;
      if (ev_two_in && (hi > lo)) begin
         pmax     = hi;
         pmax_idx = idx_hi;
      end
      if (ev_two_in && (hi < lo)) begin
         pmin     = hi;
         pmin_idx = idx_hi;
      end
   end

   assign max_in     = (pmax > base_max) ? pmax : base_max;
   assign max_idx_in = (pmax > base_max) ? pmax_idx[COUNT_W-1:0] : base_max_idx;
   assign min_in     = (pmin < base_min) ? pmin : base_min;
   assign min_idx_in = (pmin < base_min) ? pmin_idx[COUNT_W-1:0] : base_min_idx;

   assign in_lo = (idx_lo >= {1'b0, ev_start_in}) && (idx_lo < {1'b0, ev_stop_in});
   assign in_hi = ev_two_in && (idx_hi >= {1'b0, ev_start_in}) &&
                  (idx_hi < {1'b0, ev_stop_in});

   assign add_hi  = ev_two_in ? SUM_W'(hi) : '0;
   assign wadd_lo = in_lo ? SUM_W'(lo) : '0;
   assign wadd_hi = in_hi ? SUM_W'(hi) : '0;
   assign sum_in  = base_sum + SUM_W'(lo) + add_hi;
   assign wsum_in = base_wsum + wadd_lo + wadd_hi;

   assign sample_count_in = base_sc + (ev_two_in ? SAMPLE_W'(2) : SAMPLE_W'(1));
   assign word_count_in   = word_count_ff + COUNT_W'(1);
   assign done            = word_count_in >= ev_len_in;
   assign win_ok = ({1'b0, ev_start_in} < sample_count_in) &&
                   ({1'b0, ev_stop_in} < sample_count_in) &&
                   (ev_start_in < ev_stop_in);

   assign emit = step && (err || done);

   always_comb begin
      rsp = '0;
      if (err) begin
         rsp.status = short_buf ? STATUS_SHORT : STATUS_BAD_SPW;
      end else begin
         rsp.status     = STATUS_OK;
         rsp.used_words = word_count_in;
         rsp.max_value  = max_in;
         rsp.max_index  = max_idx_in;
         rsp.min_value  = min_in;
         rsp.min_index  = min_idx_in;
         rsp.total_sum  = sum_in[OSUM_W-1:0];
         rsp.window_sum = win_ok ? wsum_in[OSUM_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff   <= '0;
         sample_count_ff <= '0;
         max_ff          <= '0;
         max_idx_ff      <= '0;
         min_ff          <= '1;
         min_idx_ff      <= '0;
         sum_ff          <= '0;
         wsum_ff         <= '0;
         ev_two_ff       <= 1'b0;
         ev_len_ff       <= '0;
         ev_start_ff     <= '0;
         ev_stop_ff      <= '0;
      end else if (step && !err) begin
         word_count_ff   <= done ? '0 : word_count_in;
         sample_count_ff <= sample_count_in;
         max_ff          <= max_in;
         max_idx_ff      <= max_idx_in;
         min_ff          <= min_in;
         min_idx_ff      <= min_idx_in;
         sum_ff          <= sum_in;
         wsum_ff         <= wsum_in;
         ev_two_ff       <= ev_two_in;
         ev_len_ff       <= ev_len_in;
         ev_start_ff     <= ev_start_in;
         ev_stop_ff      <= ev_stop_in;
      end
   end

endmodule

// File: rtl/waveform_unpack_peak_sum.sv
// ----------------------------------------------------------------------------
// Waveform unpack peak sum
// Unpacks raw digitizer words of an event and reports peak, trough and sums.
// ----------------------------------------------------------------------------
// Raw words arrive on the req_ stream, one request per word, and one result
// per event leaves on the rsp_ stream. Set samples_per_word, data_words and
// the window through the csr_ write port while the block is idle; the values
// are latched on the first word of each event.
// A request is registered in the input register when it is accepted and is
// processed from there into the result register, so a result is offered once
// the request of the last word (or of a faulty first word) has passed both.
// One word is taken every cycle unless a stalled rsp_ channel holds the flow:
// the input register and the result register are the only stages, and the
// running compares and adds of one word fit between them.
// A stalled rsp_ channel holds the result register and, through it, the
// input register; req_tready drops only while both are full and held.
// Reset is synchronous; it restores the register defaults (two samples per
// word, 1024 words, empty window) and clears any event in progress.
// ----------------------------------------------------------------------------
module waveform_unpack_peak_sum
   import wups_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // data_word, words_left
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, used_words, max_value, max_index, min_value, min_index,
   // total_sum, window_sum, one zero pad bit
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "waveform_unpack_peak_sum_assert.svh"

   cfg_type             cfg_ff;
   logic                in_valid_ff;
   logic [WORD_W-1:0]   in_word_ff;
   logic [LEFT_W-1:0]   in_left_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   logic                advance, step, emit;
   rsp_type             rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spw        <= SPW_RESET;
         cfg_ff.data_words <= DW_RESET;
         cfg_ff.win_start  <= '0;
         cfg_ff.win_stop   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SPW:        cfg_ff.spw        <= csr_wdata[1:0];
            CSR_DATA_WORDS: cfg_ff.data_words <= csr_wdata;
            CSR_WIN_START:  cfg_ff.win_start  <= csr_wdata;
            CSR_WIN_STOP:   cfg_ff.win_stop   <= csr_wdata;
            default:        cfg_ff            <= cfg_ff;
         endcase
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= req_tdata[WORD_W-1:0];
         in_left_ff <= req_tdata[WORD_W+LEFT_W-1:WORD_W];
      end
   end

   wups_core #(
      .MAX_WORDS (MAX_WORDS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_word  (in_word_ff),
      .words_left (in_left_ff),
      .cfg        (cfg_ff),
      .emit       (emit),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   `WUPS_ASSERT(a_err_no_words, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status != STATUS_OK) |-> rsp_data_ff.used_words == '0)
   `WUPS_ASSERT(a_ok_has_words, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status == STATUS_OK) |-> rsp_data_ff.used_words != '0)
   `WUPS_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_word_ff) && $stable(in_left_ff))

endmodule

// File: test/waveform_unpack_peak_sum_test.sv
// ----------------------------------------------------------------------------
// Waveform unpack peak sum testbench
// Feeds raw digitizer words through the req_ stream under several register
// settings and checks every report on the rsp_ stream against a written report
// or a cycle-free model of the running peak, trough and sum extraction kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module waveform_unpack_peak_sum_test;
   import wups_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int LONG_WORDS = 160;

   typedef enum {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [WORD_W-1:0]  word;
      logic [LEFT_W-1:0]  left;
      logic [1:0]         spw;
      logic [COUNT_W-1:0] dw;
      logic [COUNT_W-1:0] ws;
      logic [COUNT_W-1:0] we;
      bit                 typed;
      rsp_type            rsp;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // data_word, words_left
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // status, used_words, max_value, max_index, min_value, min_index,
   // total_sum, window_sum, one zero pad bit
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_SPW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [1:0]         cfg_spw = SPW_RESET;
   logic [COUNT_W-1:0] cfg_words = DW_RESET;
   logic [COUNT_W-1:0] cfg_first = '0;
   logic [COUNT_W-1:0] cfg_last = '0;

   logic [COUNT_W-1:0]  word_cnt = '0;
   logic [SAMPLE_W-1:0] sample_cnt = '0;
   logic [WORD_W-1:0]   peak = '0;
   logic [COUNT_W-1:0]  peak_at = '0;
   logic [WORD_W-1:0]   trough = '1;
   logic [COUNT_W-1:0]  trough_at = '0;
   logic [SUM_W-1:0]    sum_all = '0;
   logic [SUM_W-1:0]    sum_win = '0;
   logic [1:0]          ev_spw = '0;
   logic [COUNT_W-1:0]  ev_len = '0;
   logic [COUNT_W-1:0]  ev_first = '0;
   logic [COUNT_W-1:0]  ev_last = '0;

   rsp_type awaited[$];

   int  mismatches = 0;
   int  words_fed = 0;
   int  reports_seen = 0;
   int  error_reports = 0;
   int  settings_used = 0;
   int  random_fed = 0;
   int  quiet_cycles = 0;
   int  gap_odds = 2;
   int  sink_odds = 2;
   bit  calm = 1'b0;
   bit  long_hold_asked = 1'b0;

   waveform_unpack_peak_sum dut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .csr_we,
      .csr_addr,
      .csr_wdata
   );

   always #2 clock = ~clock;

   function automatic logic [COUNT_W-1:0] event_words();
      if (cfg_words == '0) return COUNT_W'(1);
      if (cfg_words > COUNT_W'(MAX_WORDS_DEFAULT)) return COUNT_W'(MAX_WORDS_DEFAULT);
      return cfg_words;
   endfunction

   function automatic void take_sample(input logic [WORD_W-1:0] v);
      if (v > peak) begin
         peak = v;
         peak_at = sample_cnt[COUNT_W-1:0];
      end
      if (v < trough) begin
         trough = v;
         trough_at = sample_cnt[COUNT_W-1:0];
      end
      sum_all = sum_all + SUM_W'(v);
      if (sample_cnt >= {1'b0, ev_first} && sample_cnt < {1'b0, ev_last})
         sum_win = sum_win + SUM_W'(v);
      sample_cnt = sample_cnt + SAMPLE_W'(1);
   endfunction

   function automatic bit fold_word(input logic [WORD_W-1:0] word,
                                    input logic [LEFT_W-1:0] left,
                                    output rsp_type rsp);
      logic [COUNT_W-1:0] len;
      bit                 window_ok;
      rsp = '0;
      len = event_words();
      if (word_cnt == '0) begin
         if (left < LEFT_W'(len)) begin
            rsp.status = STATUS_SHORT;
            return 1'b1;
         end
         if (cfg_spw != SPW_ONE && cfg_spw != SPW_TWO) begin
            rsp.status = STATUS_BAD_SPW;
            return 1'b1;
         end
         ev_spw = cfg_spw;
         ev_len = len;
         ev_first = cfg_first;
         ev_last = cfg_last;
         sample_cnt = '0;
         peak = '0;
         peak_at = '0;
         trough = '1;
         trough_at = '0;
         sum_all = '0;
         sum_win = '0;
      end
      if (ev_spw == SPW_ONE) begin
         take_sample(word);
      end else begin
         take_sample({16'd0, word[HALF_W-1:0]});
         take_sample({16'd0, word[WORD_W-1:HALF_W]});
      end
      word_cnt = word_cnt + COUNT_W'(1);
      if (word_cnt < ev_len) return 1'b0;
      window_ok = {1'b0, ev_first} < sample_cnt && {1'b0, ev_last} < sample_cnt &&
                  ev_first < ev_last;
      rsp.status = STATUS_OK;
      rsp.used_words = word_cnt;
      rsp.max_value = peak;
      rsp.max_index = peak_at;
      rsp.min_value = trough;
      rsp.min_index = trough_at;
      rsp.total_sum = sum_all[OSUM_W-1:0];
      rsp.window_sum = window_ok ? sum_win[OSUM_W-1:0] : '0;
      word_cnt = '0;
      return 1'b1;
   endfunction

   function automatic rsp_type report(input status_type st, input logic [10:0] wr,
                                      input logic [31:0] mx, input logic [10:0] mxi,
                                      input logic [31:0] mn, input logic [10:0] mni,
                                      input logic [41:0] ts, input logic [41:0] ws);
      rsp_type r;
      r.status = st;
      r.used_words = wr;
      r.max_value = mx;
      r.max_index = mxi;
      r.min_value = mn;
      r.min_index = mni;
      r.total_sum = ts;
      r.window_sum = ws;
      return r;
   endfunction

   function automatic script_row_type csr_row(input logic [1:0] spw, input logic [10:0] dw,
                                              input logic [10:0] ws, input logic [10:0] we);
      script_row_type r;
      r = '{kind: ROW_CSR, word: '0, left: '0, spw: spw, dw: dw, ws: ws, we: we,
            typed: 1'b0, rsp: '0};
      return r;
   endfunction

   function automatic script_row_type word_row(input logic [31:0] word,
                                               input logic [15:0] left);
      script_row_type r;
      r = '{kind: ROW_WORD, word: word, left: left, spw: '0, dw: '0, ws: '0, we: '0,
            typed: 1'b0, rsp: '0};
      return r;
   endfunction

   function automatic script_row_type known_row(input logic [31:0] word,
                                                input logic [15:0] left,
                                                input rsp_type rsp);
      script_row_type r;
      r = word_row(word, left);
      r.typed = 1'b1;
      r.rsp = rsp;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Report %0d, %s: expected %0h, got %0h", reports_seen, name, want, got);
      end
   endfunction

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic offer_word(input logic [WORD_W-1:0] word, input logic [LEFT_W-1:0] left,
                             input bit typed, input rsp_type given);
      rsp_type predicted;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {left, word};
      do @(posedge clock); while (!req_tready);
      if (fold_word(word, left, predicted)) awaited.push_back(typed ? given : predicted);
      words_fed++;
      if (!calm && $urandom_range(0, 15) < gap_odds) pause_sender($urandom_range(1, 19));
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic configure(input logic [1:0] spw, input logic [COUNT_W-1:0] dw,
                            input logic [COUNT_W-1:0] ws, input logic [COUNT_W-1:0] we);
      settle();
      csr_we <= 1'b1;
      csr_addr <= CSR_SPW;
      csr_wdata <= {9'd0, spw};
      @(negedge clock);
      csr_addr <= CSR_DATA_WORDS;
      csr_wdata <= dw;
      @(negedge clock);
      csr_addr <= CSR_WIN_START;
      csr_wdata <= ws;
      @(negedge clock);
      csr_addr <= CSR_WIN_STOP;
      csr_wdata <= we;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_spw = spw;
      cfg_words = dw;
      cfg_first = ws;
      cfg_last = we;
      settings_used++;
   endtask

   initial begin : sink_pacing
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (long_hold_asked) begin
            long_hold_asked = 1'b0;
            hold = 120;
         end else if (hold == 0 && !calm && $urandom_range(0, 15) < sink_odds) begin
            hold = $urandom_range(1, 19);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : report_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         reports_seen++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Report %0d arrived with no request awaiting it.", reports_seen);
         end else begin
            want = awaited.pop_front();
            if (want.status != STATUS_OK) error_reports++;
            compare_field("status", want.status, got.status);
            compare_field("used_words", want.used_words, got.used_words);
            compare_field("max_value", want.max_value, got.max_value);
            compare_field("max_index", want.max_index, got.max_index);
            compare_field("min_value", want.min_value, got.min_value);
            compare_field("min_index", want.min_index, got.min_index);
            compare_field("total_sum", want.total_sum, got.total_sum);
            compare_field("window_sum", want.window_sum, got.window_sum);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Nothing moved on either stream for %0d cycles.", QUIET_LIMIT);
         $display("waveform_unpack_peak_sum: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      script_row_type     script[$];
      logic [1:0]         spw;
      logic [COUNT_W-1:0] dw;
      logic [COUNT_W-1:0] ws;
      logic [COUNT_W-1:0] we;
      logic [COUNT_W-1:0] span;
      logic [WORD_W-1:0]  word;
      logic [LEFT_W-1:0]  left;
      int                 burst;

      script = {
         known_row(32'h0001_0002, 16'd1023, report(STATUS_SHORT, 0, 0, 0, 0, 0, 0, 0)),
         csr_row(2'd0, 11'd1, 11'd0, 11'd0),
         known_row(32'hDEAD_BEEF, 16'hFFFF, report(STATUS_BAD_SPW, 0, 0, 0, 0, 0, 0, 0)),
         known_row(32'h1234_5678, 16'd0, report(STATUS_SHORT, 0, 0, 0, 0, 0, 0, 0)),
         csr_row(2'd3, 11'd0, 11'd0, 11'd0),
         known_row(32'h0000_0000, 16'd1, report(STATUS_BAD_SPW, 0, 0, 0, 0, 0, 0, 0)),
         csr_row(SPW_ONE, 11'd1, 11'd0, 11'd0),
         known_row(32'hFFFF_FFFF, 16'd1, report(STATUS_OK, 1, 32'hFFFF_FFFF, 0,
                                                32'hFFFF_FFFF, 0, 42'hFFFF_FFFF, 0)),
         known_row(32'h0000_0000, 16'hFFFF, report(STATUS_OK, 1, 0, 0, 0, 0, 0, 0)),
         csr_row(SPW_TWO, 11'd2, 11'd1, 11'd3),
         word_row(32'hFFFF_0000, 16'd2),
         word_row(32'h0005_FFFF, 16'd0),
         csr_row(SPW_TWO, 11'd3, 11'd5, 11'd5),
         word_row(32'h8000_7FFF, 16'd3),
         word_row(32'h0001_0001, 16'd0),
         word_row(32'hFFFE_0002, 16'd9),
         csr_row(SPW_ONE, 11'd2, 11'd0, 11'd2),
         word_row(32'h8000_0000, 16'd2),
         word_row(32'h7FFF_FFFF, 16'd0),
         csr_row(SPW_ONE, 11'd4, 11'd3, 11'd1),
         word_row(32'h0000_0005, 16'd4),
         word_row(32'h0000_0003, 16'd4),
         word_row(32'h0000_0003, 16'd4),
         word_row(32'h0000_0005, 16'd4),
         csr_row(SPW_TWO, 11'd3, 11'd0, 11'd5),
         word_row(32'h0102_0304, 16'd3),
         csr_row(SPW_ONE, 11'd1, 11'd0, 11'd0),
         word_row(32'h0506_0708, 16'd1),
         word_row(32'h090A_0B0C, 16'd1),
         word_row(32'hCAFE_F00D, 16'd1)
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR)
            configure(script[i].spw, script[i].dw, script[i].ws, script[i].we);
         else
            offer_word(script[i].word, script[i].left, script[i].typed, script[i].rsp);
      end

      // A long event, with the peak on the very last sample.
      configure(SPW_TWO, COUNT_W'(LONG_WORDS), 11'd0, COUNT_W'(2 * LONG_WORDS - 1));
      for (int k = 0; k < LONG_WORDS; k++)
         offer_word(k == LONG_WORDS - 1 ? 32'hFFFF_0000 : $urandom & 32'h7FFF_7FFF,
                    k == 0 ? LEFT_W'(LONG_WORDS) : 16'($urandom), 1'b0, '0);

      // The receiver holds off while the sender keeps offering one-word events.
      configure(SPW_ONE, 11'd1, 11'd0, 11'd0);
      gap_odds = 0;
      long_hold_asked = 1'b1;
      repeat (40) offer_word($urandom, 16'($urandom_range(1, 65535)), 1'b0, '0);

      while (random_fed < 180) begin
         case ($urandom_range(0, 9))
            0: spw = 2'd0;
            1: spw = 2'd3;
            2, 3, 4, 5: spw = SPW_ONE;
            default: spw = SPW_TWO;
         endcase
         case ($urandom_range(0, 9))
            0: dw = 11'd0;
            1: dw = 11'($urandom_range(9, 40));
            default: dw = 11'($urandom_range(1, 8));
         endcase
         span = (dw == 0 ? 11'd1 : dw) * (spw == SPW_ONE ? 11'd1 : 11'd2);
         if ($urandom_range(0, 4) == 0) begin
            ws = 11'($urandom_range(0, 2047));
            we = 11'($urandom_range(0, 2047));
         end else begin
            ws = 11'($urandom_range(0, span));
            we = 11'($urandom_range(0, span));
         end
         configure(spw, dw, ws, we);
         gap_odds = $urandom_range(0, 4);
         sink_odds = $urandom_range(0, 4);
         burst = $urandom_range(10, 40);
         repeat (burst) begin
            calm = (random_fed >= 150);
            case ($urandom_range(0, 7))
               0: word = 32'h0000_0000;
               1: word = 32'hFFFF_FFFF;
               2: word = 32'hFFFF_0000;
               3: word = 32'h0001_0001 * $urandom_range(0, 3);
               default: word = $urandom;
            endcase
            case ($urandom_range(0, 9))
               0: left = 16'($urandom_range(0, 65535));
               1: left = 16'(event_words() - 1);
               default: left = 16'($urandom_range(event_words(), 65535));
            endcase
            offer_word(word, left, 1'b0, '0);
            random_fed++;
         end
      end

      calm = 1'b1;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Fed %0d words under %0d register settings, including a %0d-word event",
               words_fed, settings_used, LONG_WORDS);
      $display("and a long receiver hold; checked %0d reports, %0d of them error reports.",
               reports_seen, error_reports);
      if (mismatches == 0)
         $display("waveform_unpack_peak_sum: match");
      else
         $display("waveform_unpack_peak_sum: mismatch");
      $finish;
   end

endmodule
